// ----- rtl/rde_pkg.sv -----
package rde_pkg;

    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int NUM_SYMBOLS = 16;
    localparam int SYM_IDX_W   = 4;
    localparam int SYM_WORD_W  = 64;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CHAR_W-1:0] SIGN_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR = 8'h2B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX  = 2'd0,
        CFG_SYM_LO = 2'd1,
        CFG_SYM_HI = 2'd2
    } t_cfg_idx;

    function automatic logic [CHAR_W-1:0] symbol_of(
        input logic [SYM_WORD_W-1:0] sym_lo,
        input logic [SYM_WORD_W-1:0] sym_hi,
        input logic [DIGIT_W-1:0]    digit
    );
        logic [2:0] slot;
        slot = digit[2:0];
        if (digit[3]) begin
            return sym_hi[slot*CHAR_W +: CHAR_W];
        end
        return sym_lo[slot*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ----- rtl/rde_divider.sv -----
module rde_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [VALUE_BITS-1:0]          i_dividend,
    input  logic [rde_pkg::RADIX_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [VALUE_BITS-1:0]          o_quot,
    output logic [rde_pkg::RADIX_W-1:0]    o_rem
);

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [VALUE_BITS-1:0]       r_q;
    logic [rde_pkg::RADIX_W-1:0] r_rem;

    logic [rde_pkg::RADIX_W:0]   trial;
    logic                        ge;
    logic [rde_pkg::RADIX_W:0]   diff;
    logic [rde_pkg::RADIX_W-1:0] n_rem;

    // restoring divide, one quotient bit per cycle
    assign trial = {r_rem, r_q[VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};
    assign n_rem = ge ? diff[rde_pkg::RADIX_W-1:0] : trial[rde_pkg::RADIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(VALUE_BITS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[VALUE_BITS-2:0], ge};
                r_rem <= n_rem;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("divider did not finish after last bit");

endmodule

// ----- rtl/rde_symbol_check.sv -----
module rde_symbol_check (
    input  logic [rde_pkg::SYM_WORD_W-1:0] i_sym_lo,
    input  logic [rde_pkg::SYM_WORD_W-1:0] i_sym_hi,
    input  logic [rde_pkg::RADIX_W-1:0]    i_radix,
    input  logic [rde_pkg::SYM_IDX_W-1:0]  i_idx,
    output logic                           o_bad
);

    logic [rde_pkg::CHAR_W-1:0] cur;

    // symbol at i_idx against the sign bytes and every later symbol in use
    always_comb begin
        cur   = rde_pkg::symbol_of(i_sym_lo, i_sym_hi, i_idx);
        o_bad = (cur == rde_pkg::SIGN_CHAR) || (cur == rde_pkg::PLUS_CHAR);
        for (int j = 0; j < rde_pkg::NUM_SYMBOLS; j++) begin
            if ((rde_pkg::SYM_IDX_W'(j) > i_idx) && (rde_pkg::RADIX_W'(j) < i_radix) &&
                (rde_pkg::symbol_of(i_sym_lo, i_sym_hi, rde_pkg::DIGIT_W'(j)) == cur)) begin
                o_bad = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/radix_digit_emitter.sv -----
// Converts a signed VALUE_BITS-bit value to text in a radix of 2 to MAX_RADIX, one character
// per output request, most significant digit first, with a leading '-' for negative values;
// o_last marks the final character. Digit d is emitted as symbol byte d of the symbol
// registers. A request is dropped without output if the radix is below 2 or above MAX_RADIX,
// or if a symbol in use is '+' or '-' or repeats. One request is processed at a time: the
// symbols in use are checked one by one, then each digit is computed in the bit-serial
// divider, which is reused for every digit, then each digit character passes the FETCH,
// LOAD and OUT states (held in OUT under output stall). The user must write configuration
// only while idle; the block itself does not enforce this.
module radix_digit_emitter #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rde_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rde_pkg::SYM_WORD_W-1:0]    i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [VALUE_BITS-1:0]      i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rde_pkg::CHAR_W-1:0]        o_out_char,
    output logic                              o_last
);

    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FETCH,
        S_LOAD,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [rde_pkg::RADIX_W-1:0]     r_radix;
    logic [rde_pkg::SYM_WORD_W-1:0]  r_sym_lo;
    logic [rde_pkg::SYM_WORD_W-1:0]  r_sym_hi;
    logic [rde_pkg::SYM_IDX_W-1:0]   r_idx;
    logic                            r_neg;
    logic [VALUE_BITS-1:0]           r_mag;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_div_start;
    logic                            r_oval;
    logic [rde_pkg::CHAR_W-1:0]      r_ochar;
    logic                            r_olast;
    logic [rde_pkg::DIGIT_W-1:0]     r_rd_data;
    logic [rde_pkg::DIGIT_W-1:0]     r_digits [VALUE_BITS];

    logic                            accept;
    logic                            sym_bad;
    logic                            div_done;
    logic [VALUE_BITS-1:0]           div_quot;
    logic [rde_pkg::RADIX_W-1:0]     div_rem;
    logic                            dig_we;
    logic [CNT_W-1:0]                cnt_dec;
    logic [ADDR_W-1:0]               rd_addr;
    logic [VALUE_BITS-1:0]           mag_in;
    logic                            radix_ok;
    logic                            check_end;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign mag_in    = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;
    assign radix_ok  = (r_radix >= rde_pkg::RADIX_W'(2)) &&
                       (r_radix <= rde_pkg::RADIX_W'(MAX_RADIX));
    assign check_end = (rde_pkg::RADIX_W'(r_idx) + rde_pkg::RADIX_W'(1)) == r_radix;
    assign dig_we    = (r_state == S_DIV) && div_done;
    assign cnt_dec   = r_cnt - CNT_W'(1);
    assign rd_addr   = cnt_dec[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= '0;
            r_sym_lo <= '0;
            r_sym_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (rde_pkg::t_cfg_idx'(i_cfg_idx))
                rde_pkg::CFG_RADIX:  r_radix  <= i_cfg_wdata[rde_pkg::RADIX_W-1:0];
                rde_pkg::CFG_SYM_LO: r_sym_lo <= i_cfg_wdata;
                rde_pkg::CFG_SYM_HI: r_sym_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rde_symbol_check u_check (
        .i_sym_lo (r_sym_lo),
        .i_sym_hi (r_sym_hi),
        .i_radix  (r_radix),
        .i_idx    (r_idx),
        .o_bad    (sym_bad)
    );

    rde_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_digits[r_cnt[ADDR_W-1:0]] <= div_rem[rde_pkg::DIGIT_W-1:0];
        end
        r_rd_data <= r_digits[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_div_start <= 1'b0;
            r_oval      <= 1'b0;
            r_olast     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && radix_ok) begin
                        r_neg   <= i_value[VALUE_BITS-1];
                        r_mag   <= mag_in;
                        r_cnt   <= '0;
                        r_idx   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (sym_bad) begin
                        r_state <= S_IDLE;
                    end else if (check_end) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_idx <= r_idx + rde_pkg::SYM_IDX_W'(1);
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        if ((div_quot == '0) || (r_cnt == CNT_W'(VALUE_BITS - 1))) begin
                            if (r_neg) begin
                                r_ochar <= rde_pkg::SIGN_CHAR;
                                r_olast <= 1'b0;
                                r_oval  <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_FETCH;
                            end
                        end else begin
                            r_mag       <= div_quot;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_FETCH: begin
                    r_cnt   <= cnt_dec;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_ochar <= rde_pkg::symbol_of(r_sym_lo, r_sym_hi, r_rd_data);
                    r_olast <= (r_cnt == '0);
                    r_oval  <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oval  <= 1'b0;
                        r_state <= r_olast ? S_IDLE : S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_oval;
    assign o_out_char = r_ochar;
    assign o_last     = r_olast;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(VALUE_BITS))
        else $error("digit count beyond store depth");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_cnt == '0))
        else $error("last character flagged with digits left");

    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_char == rde_pkg::SIGN_CHAR && r_state == S_OUT && r_cnt != '0)
        |-> !o_last)
        else $error("sign flagged as last character");

endmodule
